@@ hdl/cursor_line_edit_buffer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the line-edit buffer
// Concurrent checks sampled on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef CURSOR_LINE_EDIT_BUFFER_TOP_MACROS_SVH
`define CURSOR_LINE_EDIT_BUFFER_TOP_MACROS_SVH

// Same-cycle implication
`define CLEB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CLEB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cleb_pkg.sv @@
// ----------------------------------------------------------------------------
// cleb_pkg
// Shared types and constants for the gap-buffer line-edit block.
// ----------------------------------------------------------------------------
package cleb_pkg;

  // Default store depth in characters
  localparam int CLEB_DEPTH = 256;

  // Key codes with special meaning
  localparam logic [7:0] KEY_LEFT  = 8'h3C;  // '<'
  localparam logic [7:0] KEY_RIGHT = 8'h3E;  // '>'
  localparam logic [7:0] KEY_BACK  = 8'h2D;  // '-'

  // Request kinds
  typedef enum logic [1:0] {
    REQ_KEY   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  // Decoded operation of an accepted item
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LEFT,
    OP_RIGHT,
    OP_BACK,
    OP_INSERT,
    OP_DROP,
    OP_READ,
    OP_BAD,
    OP_CLEAR
  } op_t;

  // Control sequencer states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

@@ hdl/cleb_ram.sv @@
// ----------------------------------------------------------------------------
// cleb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cleb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/cursor_line_edit_buffer_top.sv @@
// Result: the accepting edge registers the item's op and enters the execute state;
//   the result loads into the output register once that register is free.
// No item is accepted while one executes; the store's registered read must land
//   before a cursor move writes the character back at the other side of the gap.
// A finished result waits in the output register while the next item is accepted.
// Reset: counters cleared, output empty; store not cleared, ready in the first cycle.
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_top
// Gap-buffer line editor: characters left of the cursor packed from entry 0,
// characters right of the cursor packed down from the top entry.
// ----------------------------------------------------------------------------
`include "cursor_line_edit_buffer_top_macros.svh"

module cursor_line_edit_buffer_top import cleb_pkg::*; #(
  parameter int DEPTH = CLEB_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] key, [15:8] read_index
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] read_char, [16:8] line_length,
                                      // [25:17] cursor_pos, [31:26] zero
  output logic [1:0]  m_axis_tuser    // [0] full_drop, [1] index_bad
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = CW + 9;

  // Input fields
  logic [7:0] in_key;
  logic [7:0] in_idx;
  assign in_key = s_axis_tdata[7:0];
  assign in_idx = s_axis_tdata[15:8];

  // Control and counters
  state_t        state, state_next;
  logic [CW-1:0] left, left_next;
  logic [CW-1:0] right, right_next;
  logic [CW-1:0] len, len_next;
  op_t           op_in;
  op_t           op;
  logic          accept;
  logic          out_free;
  logic          load;

  // Store port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Result staging and output register
  logic [7:0] res_char;
  logic       res_drop;
  logic       res_bad;
  logic [7:0] out_char;
  logic [8:0] out_len;
  logic [8:0] out_cursor;
  logic       out_drop;
  logic       out_bad;

  assign len      = left + right;
  assign len_next = left_next + right_next;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Decode the offered item against the current counters
  always_comb begin
    op_in = OP_NOP;
    case (s_axis_tuser)
      REQ_KEY: begin
        case (in_key)
          KEY_LEFT:  op_in = (left != '0)  ? OP_LEFT  : OP_NOP;
          KEY_RIGHT: op_in = (right != '0) ? OP_RIGHT : OP_NOP;
          KEY_BACK:  op_in = (left != '0)  ? OP_BACK  : OP_NOP;
          default:   op_in = (len < CW'(DEPTH)) ? OP_INSERT : OP_DROP;
        endcase
      end
      REQ_READ:  op_in = (EW'(in_idx) >= EW'(len)) ? OP_BAD : OP_READ;
      REQ_CLEAR: op_in = OP_CLEAR;
      default:   op_in = OP_NOP;
    endcase
  end

  // Sequencer: issue read or insert on accept, write back and count on execute
  always_comb begin
    state_next    = state;
    left_next     = left;
    right_next    = right;
    s_axis_tready = (state == S_IDLE);
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    load          = 1'b0;
    res_char      = '0;
    res_drop      = 1'b0;
    res_bad       = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_EXEC;
          case (op_in)
            OP_LEFT: begin
              ram_re    = 1'b1;
              ram_raddr = AW'(left - CW'(1));
            end
            OP_RIGHT: begin
              ram_re    = 1'b1;
              ram_raddr = AW'(CW'(DEPTH) - right);
            end
            OP_READ: begin
              ram_re = 1'b1;
              if (EW'(in_idx) < EW'(left)) begin
                ram_raddr = AW'(in_idx);
              end else begin
                ram_raddr = AW'(EW'(DEPTH) - EW'(right) + EW'(in_idx) - EW'(left));
              end
            end
            OP_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = AW'(left);
              ram_wdata = in_key;
            end
            default: ;
          endcase
        end
      end
      S_EXEC: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
          case (op)
            OP_LEFT: begin
              ram_we     = 1'b1;
              ram_waddr  = AW'(CW'(DEPTH) - right - CW'(1));
              ram_wdata  = ram_rdata;
              left_next  = left - CW'(1);
              right_next = right + CW'(1);
            end
            OP_RIGHT: begin
              ram_we     = 1'b1;
              ram_waddr  = AW'(left);
              ram_wdata  = ram_rdata;
              left_next  = left + CW'(1);
              right_next = right - CW'(1);
            end
            OP_BACK:   left_next = left - CW'(1);
            OP_INSERT: left_next = left + CW'(1);
            OP_DROP:   res_drop  = 1'b1;
            OP_READ:   res_char  = ram_rdata;
            OP_BAD:    res_bad   = 1'b1;
            OP_CLEAR: begin
              left_next  = '0;
              right_next = '0;
            end
            default: ;
          endcase
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      left          <= '0;
      right         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      left  <= left_next;
      right <= right_next;
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op <= op_in;
    end
    if (load) begin
      out_char   <= res_char;
      out_len    <= 9'(len_next);
      out_cursor <= 9'(left_next);
      out_drop   <= res_drop;
      out_bad    <= res_bad;
    end
  end

  assign m_axis_tdata = {6'b0, out_cursor, out_len, out_char};
  assign m_axis_tuser = {out_bad, out_drop};

  // Character store
  cleb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Checks
  `CLEB_ASSERT_NOW(a_len_bound, 1'b1, len <= CW'(DEPTH), "line length above store depth")
  `CLEB_ASSERT_NEXT(a_accept_exec, accept, state == S_EXEC, "accepted item not executed")
  `CLEB_ASSERT_NOW(a_port_excl, ram_we, !ram_re, "store read and write in one cycle")
  `CLEB_ASSERT_NOW(a_drop_full, (state == S_EXEC) && (op == OP_DROP), len == CW'(DEPTH),
                   "insert dropped while store not full")

endmodule

@@ tb/cursor_line_edit_buffer_top_test.sv @@
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_top_test
// Self-checking bench for the gap-buffer line editor. A driver feeds key, read,
// clear and unused items in bursts. The receiver stalls in changing patterns.
// A shadow gap buffer predicts every result, and the monitor compares each
// result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cursor_line_edit_buffer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cleb_pkg::*;

  localparam int         DEPTH_N     = CLEB_DEPTH;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         DRAIN_WAIT  = 20;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;   // request code the block ignores

  // One request on the input stream
  typedef struct {
    logic [1:0] kind;
    logic [7:0] key;
    logic [7:0] index;
    bit         hold;       // wait for all results before sending
  } edit_req_t;

  // One result of the output stream
  typedef struct packed {
    logic [7:0] ch;
    logic [8:0] len;
    logic [8:0] cur;
    logic       drop;
    logic       bad;
  } line_result_t;

  // Receiver stall modes
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_THIRD,
    RX_SPARSE
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [7:0] key, [15:8] read_index
  logic [1:0]  s_axis_tuser = '0;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [7:0] read_char, [16:8] line_length,
                                    // [25:17] cursor_pos
  logic [1:0]  m_axis_tuser;        // [0] full_drop, [1] index_bad

  edit_req_t    edit_requests[$];
  line_result_t expected_lines[$];
  logic         line_idle = 1'b1;
  int           error_count = 0;
  int           cycle_count = 0;

  // Shadow gap buffer
  logic [7:0] shadow_store [DEPTH_N];
  int         left_n;
  int         right_n;

  // Driver pacing
  int burst_left = 1;
  int gap_left = 0;

  // Receiver pacing
  rx_mode_t rx_mode = RX_OPEN;
  int       mode_left = 0;

  cursor_line_edit_buffer_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one request to the shadow buffer and return the result it gives
  function automatic line_result_t apply_edit(logic [1:0] kind, logic [7:0] key,
                                              logic [7:0] index);
    line_result_t r;
    int idx;
    r = '0;
    idx = int'(index);
    case (kind)
      REQ_KEY: begin
        if (key == KEY_LEFT) begin
          if (left_n > 0) begin
            shadow_store[DEPTH_N - right_n - 1] = shadow_store[left_n - 1];
            left_n--;
            right_n++;
          end
        end else if (key == KEY_RIGHT) begin
          if (right_n > 0) begin
            shadow_store[left_n] = shadow_store[DEPTH_N - right_n];
            left_n++;
            right_n--;
          end
        end else if (key == KEY_BACK) begin
          if (left_n > 0) left_n--;
        end else if (left_n + right_n < DEPTH_N) begin
          shadow_store[left_n] = key;
          left_n++;
        end else begin
          r.drop = 1'b1;
        end
      end
      REQ_READ: begin
        if (idx >= left_n + right_n) r.bad = 1'b1;
        else if (idx < left_n) r.ch = shadow_store[idx];
        else r.ch = shadow_store[DEPTH_N - right_n + (idx - left_n)];
      end
      REQ_CLEAR: begin
        left_n = 0;
        right_n = 0;
      end
      default: ;  // unused code leaves the line alone
    endcase
    r.len = 9'(left_n + right_n);
    r.cur = 9'(left_n);
    return r;
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      error_count++;
    end
  endfunction

  task automatic add_item(logic [1:0] kind, logic [7:0] key, logic [7:0] index,
                          bit hold = 1'b0);
    edit_req_t r;
    r.kind = kind;
    r.key = key;
    r.index = index;
    r.hold = hold;
    edit_requests.push_back(r);
  endtask

  // Byte that inserts: printable text, or any byte when wide is set
  function automatic logic [7:0] insert_byte(bit wide);
    logic [7:0] b;
    b = wide ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7E));
    if (b == KEY_LEFT || b == KEY_RIGHT || b == KEY_BACK) b = b ^ 8'h80;
    return b;
  endfunction

  // Driver: bursts of items with random gaps
  always @(posedge clk) begin
    logic took;
    logic show;
    took = s_axis_tvalid && s_axis_tready;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (took) void'(edit_requests.pop_front());
      if (!s_axis_tvalid || took) begin
        show = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (edit_requests.size() != 0 &&
                     (!edit_requests[0].hold || (line_idle && !took))) begin
          show = 1'b1;
          s_axis_tuser <= edit_requests[0].kind;
          s_axis_tdata <= {edit_requests[0].index, edit_requests[0].key};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        s_axis_tvalid <= show;
      end
    end
  end

  // Receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN:  m_axis_tready <= 1'b1;
        RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
        RX_THIRD: m_axis_tready <= (cycle_count % 3 == 0);
        default:  m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    line_result_t want;
    if (rst) begin
      left_n = 0;
      right_n = 0;
      line_idle <= 1'b1;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_lines.push_back(apply_edit(s_axis_tuser, s_axis_tdata[7:0],
                                            s_axis_tdata[15:8]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_lines.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got %h/%b",
                   $time, m_axis_tdata, m_axis_tuser);
          error_count++;
        end else begin
          want = expected_lines.pop_front();
          check_field("read_char", int'(want.ch), int'(m_axis_tdata[7:0]));
          check_field("line_length", int'(want.len), int'(m_axis_tdata[16:8]));
          check_field("cursor_pos", int'(want.cur), int'(m_axis_tdata[25:17]));
          check_field("full_drop", int'(want.drop), int'(m_axis_tuser[0]));
          check_field("index_bad", int'(want.bad), int'(m_axis_tuser[1]));
        end
      end
      line_idle <= (expected_lines.size() == 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int n;
    int sel;
    int random_count;

    // Empty line: moves and backspace at the ends, reads out of range, unused code
    add_item(REQ_KEY, KEY_LEFT, 8'h00);
    add_item(REQ_KEY, KEY_RIGHT, 8'hFF);
    add_item(REQ_KEY, KEY_BACK, 8'h00);
    add_item(REQ_READ, 8'h00, 8'h00);
    add_item(REQ_READ, 8'hFF, 8'hFF);
    add_item(REQ_UNUSED, 8'h41, 8'h05);
    // Type a short line including the extreme byte values
    add_item(REQ_KEY, 8'h61, 8'h00);
    add_item(REQ_KEY, 8'h62, 8'h00);
    add_item(REQ_KEY, 8'h00, 8'h00);
    add_item(REQ_KEY, 8'hFF, 8'h00);
    add_item(REQ_KEY, KEY_LEFT, 8'h00);
    add_item(REQ_KEY, KEY_LEFT, 8'h00);
    add_item(REQ_KEY, KEY_RIGHT, 8'h00);
    add_item(REQ_READ, 8'h00, 8'h00);
    add_item(REQ_READ, 8'h00, 8'h03);
    add_item(REQ_READ, 8'h00, 8'h04);
    add_item(REQ_KEY, KEY_BACK, 8'h00);
    add_item(REQ_KEY, KEY_RIGHT, 8'h00);
    add_item(REQ_KEY, KEY_RIGHT, 8'h00);
    add_item(REQ_READ, 8'h00, 8'h02);
    add_item(REQ_UNUSED, 8'hFF, 8'hFF);
    add_item(REQ_CLEAR, 8'hFF, 8'hFF);
    add_item(REQ_READ, 8'h00, 8'h00);

    // Fill the line to capacity after a full drain, then work at the limit
    add_item(REQ_CLEAR, 8'($urandom), 8'($urandom), 1'b1);
    for (int i = 0; i < DEPTH_N; i++)
      add_item(REQ_KEY, insert_byte($urandom_range(0, 3) == 0), 8'($urandom));
    for (int i = 0; i < 3; i++) add_item(REQ_KEY, insert_byte(1'b1), 8'($urandom));
    n = $urandom_range(3, 9);
    for (int i = 0; i < n; i++) add_item(REQ_KEY, KEY_LEFT, 8'($urandom));
    add_item(REQ_READ, 8'($urandom), 8'h00);
    add_item(REQ_READ, 8'($urandom), 8'hFF);
    for (int i = 0; i < 6; i++) add_item(REQ_READ, 8'($urandom), 8'($urandom));
    add_item(REQ_KEY, insert_byte(1'b0), 8'($urandom));
    add_item(REQ_KEY, KEY_BACK, 8'($urandom));
    add_item(REQ_KEY, insert_byte(1'b1), 8'($urandom));
    add_item(REQ_KEY, insert_byte(1'b1), 8'($urandom));
    add_item(REQ_KEY, KEY_RIGHT, 8'($urandom));
    add_item(REQ_KEY, KEY_RIGHT, 8'($urandom));
    for (int i = 0; i < 4; i++) add_item(REQ_READ, 8'($urandom), 8'($urandom));
    add_item(REQ_CLEAR, 8'($urandom), 8'($urandom), 1'b1);

    // Random edit sessions: typing, cursor walks, reads, clears and noise
    random_count = 0;
    while (random_count < 220) begin
      sel = $urandom_range(0, 19);
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        if (sel < 8) begin
          if ($urandom_range(0, 7) == 0) add_item(REQ_KEY, KEY_BACK, 8'($urandom));
          else add_item(REQ_KEY, insert_byte($urandom_range(0, 4) == 0), 8'($urandom));
        end else if (sel < 12) begin
          case ($urandom_range(0, 4))
            0, 1:    add_item(REQ_KEY, KEY_LEFT, 8'($urandom));
            2, 3:    add_item(REQ_KEY, KEY_RIGHT, 8'($urandom));
            default: add_item(REQ_KEY, KEY_BACK, 8'($urandom));
          endcase
        end else if (sel < 17) begin
          if ($urandom_range(0, 5) == 0)
            add_item(REQ_READ, 8'($urandom), 8'($urandom));
          else
            add_item(REQ_READ, 8'($urandom), 8'($urandom_range(0, 24)));
        end else if (sel < 19) begin
          add_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
        end else begin
          add_item(REQ_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
          i = n;
        end
        random_count++;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (edit_requests.size() != 0 || !line_idle) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && expected_lines.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/cleb_pkg.sv
hdl/cleb_ram.sv
hdl/cursor_line_edit_buffer_top.sv
tb/cursor_line_edit_buffer_top_test.sv
